// File: rtl/sts_pkg.sv
// -----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, status and command codes, microcode word layout and the
// control program of the sorted table binary search unit.
// -----------------------------------------------------------------------------
package sts_pkg;

   // Payload widths of the request and response items.
   localparam int KEY_W    = 32;
   localparam int CMD_W    = 1;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 7;
   localparam int HELD_W   = 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_APPEND = 1'b0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // Step counter of the sequencer.
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH   = step_type'(0);
   localparam step_type STEP_APPEND  = step_type'(1);
   localparam step_type STEP_INIT    = step_type'(2);
   localparam step_type STEP_PROBE   = step_type'(3);
   localparam step_type STEP_COMPARE = step_type'(4);
   localparam step_type STEP_RESULT  = step_type'(5);

   // Datapath operation selected by a control word.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_APPEND,
      OP_INIT,
      OP_PROBE,
      OP_COMPARE,
      OP_OUTPUT
   } op_type;

   // Jump condition of a control word.
   typedef enum logic [2:0] {
      COND_ALWAYS,  // jump to target
      COND_REQ,     // hold until an item arrives; searches jump, appends fall through
      COND_EMPTY,   // jump when the search range is empty
      COND_MISS,    // jump when the probed key differs from the target
      COND_OUT      // hold while the response register is occupied, then jump
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   // Control store: one word per step.
   function automatic ucode_type ucode_word(input step_type step);
      ucode_type word;
      begin
         word = '{req_ready: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: STEP_FETCH};
         unique case (step)
            STEP_FETCH: begin
               word = '{req_ready: 1'b1, op: OP_NONE, cond: COND_REQ, target: STEP_INIT};
            end
            STEP_APPEND: begin
               word = '{req_ready: 1'b0, op: OP_APPEND, cond: COND_ALWAYS,
                        target: STEP_RESULT};
            end
            STEP_INIT: begin
               word = '{req_ready: 1'b0, op: OP_INIT, cond: COND_ALWAYS,
                        target: STEP_PROBE};
            end
            STEP_PROBE: begin
               word = '{req_ready: 1'b0, op: OP_PROBE, cond: COND_EMPTY,
                        target: STEP_RESULT};
            end
            STEP_COMPARE: begin
               word = '{req_ready: 1'b0, op: OP_COMPARE, cond: COND_MISS,
                        target: STEP_PROBE};
            end
            STEP_RESULT: begin
               word = '{req_ready: 1'b0, op: OP_OUTPUT, cond: COND_OUT,
                        target: STEP_FETCH};
            end
            default: begin
               word = '{req_ready: 1'b0, op: OP_NONE, cond: COND_ALWAYS,
                        target: STEP_FETCH};
            end
         endcase
         return word;
      end
   endfunction

endpackage

// File: rtl/sts_if.sv
// -----------------------------------------------------------------------------
// Sorted table search channels
// Valid/ready channels for request items and response items.
// -----------------------------------------------------------------------------

// Request channel: a command and a key.
interface sts_req_if import sts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [KEY_W-1:0] key;

   modport source (output valid, output command, output key, input ready);
   modport sink   (input valid, input command, input key, output ready);
endinterface

// Response channel: status, position and the number of keys held.
interface sts_rsp_if import sts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic [HELD_W-1:0]   entries_held;

   modport source (output valid, output status, output position, output entries_held,
                   input ready);
   modport sink   (input valid, input status, input position, input entries_held,
                   output ready);
endinterface

// File: rtl/sorted_table_binary_search_unit.sv
// Sequence: an append passes through the append and result steps; a search passes
// through the init step, then probe and compare steps until a compare hits or the
// range is empty (at most log2(TABLE_DEPTH)+1 compares), then the result step.
// One item at a time: the next item can be taken in the cycle after the response is
// loaded, while the receiver keeps up. Reset empties the table at once; no sweep.
// -----------------------------------------------------------------------------
// Sorted table binary search unit
// Holds signed keys, which the user must append in ascending order (not checked),
// in a memory; a microcoded sequencer and small search datapath answer all items.
// -----------------------------------------------------------------------------
module sorted_table_binary_search_unit import sts_pkg::*; #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_chan,
   sts_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Sequencer state.
   step_type  pc_ff, pc_in;
   ucode_type uword;

   // Datapath registers.
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [POS_W-1:0]    res_pos_ff, res_pos_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [HELD_W-1:0]   rsp_held_ff, rsp_held_in;

   // Key memory.
   logic [KEY_W-1:0] key_store [TABLE_DEPTH];
   logic [KEY_W-1:0] rd_data_ff;
   logic             mem_we;
   logic             mem_rd_en;

   // Condition flags.
   logic             req_fire;
   logic             range_empty;
   logic             key_hit;
   logic             key_less;
   logic             table_full;
   logic             out_free;
   logic [CNT_W:0]   mid_sum;

   // Fetch the control word of the current step.
   always_comb begin
      uword = ucode_word(pc_ff);
   end

   assign req_chan.ready = uword.req_ready;
   assign req_fire       = req_chan.valid && uword.req_ready;

   assign range_empty = lo_ff >= hi_ff;
   assign key_hit     = key_ff == rd_data_ff;
   assign key_less    = $signed(key_ff) < $signed(rd_data_ff);
   assign table_full  = count_ff == CNT_W'(TABLE_DEPTH);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;

   // Midpoint of the inclusive range lo .. hi-1, rounded down.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W + 1)'(1);

   // Next step: fall through, jump or hold, as the word's condition says.
   always_comb begin
      pc_in = step_type'(pc_ff + 1'b1);
      case (uword.cond)
         COND_ALWAYS: begin
            pc_in = uword.target;
         end
         COND_REQ: begin
            if (!req_chan.valid) begin
               pc_in = pc_ff;
            end else if (req_chan.command == CMD_SEARCH) begin
               pc_in = uword.target;
            end
         end
         COND_EMPTY: begin
            if (range_empty) begin
               pc_in = uword.target;
            end
         end
         COND_MISS: begin
            if (!key_hit) begin
               pc_in = uword.target;
            end
         end
         COND_OUT: begin
            pc_in = out_free ? uword.target : pc_ff;
         end
         default: begin
            pc_in = STEP_FETCH;
         end
      endcase
   end

   // Datapath operations under control of the current word.
   always_comb begin
      key_in        = key_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_held_in   = rsp_held_ff;
      mem_we        = 1'b0;
      mem_rd_en     = 1'b0;

      if (req_fire) begin
         key_in = req_chan.key;
      end

      case (uword.op)
         OP_APPEND: begin
            if (table_full) begin
               res_status_in = ST_FULL;
               res_pos_in    = '0;
            end else begin
               mem_we        = 1'b1;
               res_status_in = ST_OK;
               res_pos_in    = POS_W'(count_ff);
               count_in      = count_ff + 1'b1;
            end
         end
         OP_INIT: begin
            lo_in         = '0;
            hi_in         = count_ff;
            res_status_in = ST_NOT_FOUND;
            res_pos_in    = '0;
         end
         OP_PROBE: begin
            // The read is only used when the range is not empty.
            mid_in    = IDX_W'(mid_sum[CNT_W:1]);
            mem_rd_en = !range_empty;
         end
         OP_COMPARE: begin
            if (key_hit) begin
               res_status_in = ST_OK;
               res_pos_in    = POS_W'(mid_ff);
            end else if (key_less) begin
               hi_in = CNT_W'(mid_ff);
            end else begin
               lo_in = CNT_W'(mid_ff) + 1'b1;
            end
         end
         OP_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_held_in   = HELD_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_FETCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_held_ff   <= rsp_held_in;
   end

   // Key memory: one write port at the table end, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_store[count_ff[IDX_W-1:0]] <= key_ff;
      end
      if (mem_rd_en) begin
         rd_data_ff <= key_store[mid_in];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.position     = rsp_pos_ff;
   assign rsp_chan.entries_held = rsp_held_ff;

`ifndef SYNTHESIS
   // The table never holds more keys than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // A compare always follows the probe that issued its memory read.
   a_compare_after_probe: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_COMPARE) |-> ($past(pc_ff) == STEP_PROBE))
      else $error("compare step entered without a probe");

   // The search range stays ordered and within the held entries.
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_PROBE || pc_ff == STEP_COMPARE) |->
         (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search range out of order");

   // A response is loaded only by the result step.
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(pc_ff) == STEP_RESULT))
      else $error("response raised outside the result step");
`endif

endmodule
